// File: rtl/cfvd_pkg.sv
package cfvd_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF  = 16;
  localparam int unsigned COUNTER_BITS_DEF = 16;
  localparam int unsigned FIXED_BYTES      = 4;
  localparam int unsigned CODE_W           = 6;
  localparam int unsigned NUM_CODES        = 1 << CODE_W;
  localparam int unsigned NUM_CTRS         = 5;

  typedef enum logic [1:0] {
    ACT_START  = 2'd0,
    ACT_DATA   = 2'd1,
    ACT_STOP   = 2'd2,
    ACT_BUSERR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_APPLIED = 2'd0,
    ST_DUP     = 2'd1,
    ST_BAD     = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CT_APPLIED = 3'd0,
    CT_DUP     = 3'd1,
    CT_BAD     = 3'd2,
    CT_UNKNOWN = 3'd3,
    CT_BUSERR  = 3'd4
  } ctr_t;

  // frame state as seen at a stop
  typedef struct packed {
    logic       nonempty;
    logic       ok;
    logic [7:0] cmd;
    logic [7:0] len;
    logic [7:0] phead;
    logic [7:0] seq;
  } frame_info_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  command_code;
    logic [1:0]  timing_quant;
    logic [7:0]  body_len;
    logic [7:0]  first_payload_byte;
    logic [7:0]  sequence_number;
    logic [15:0] applied_count;
    logic [15:0] duplicate_count;
    logic [15:0] bad_frame_count;
    logic [15:0] unknown_count;
    logic [15:0] bus_error_count;
  } result_t;

  function automatic logic code_known(input logic [CODE_W-1:0] code);
    return (code == 6'h00) || (code == 6'h01) || (code == 6'h02) || (code == 6'h3F) ||
           ((code >= 6'h10) && (code <= 6'h17));
  endfunction

endpackage

// File: rtl/cfvd_if.sv
interface cfvd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface cfvd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  command_code;
  logic [1:0]  timing_quant;
  logic [7:0]  body_len;
  logic [7:0]  first_payload_byte;
  logic [7:0]  sequence_number;
  logic [15:0] applied_count;
  logic [15:0] duplicate_count;
  logic [15:0] bad_frame_count;
  logic [15:0] unknown_count;
  logic [15:0] bus_error_count;

  modport source (
    output valid, output status, output command_code, output timing_quant,
    output body_len, output first_payload_byte, output sequence_number,
    output applied_count, output duplicate_count, output bad_frame_count,
    output unknown_count, output bus_error_count, input ready
  );
  modport sink (
    input valid, input status, input command_code, input timing_quant,
    input body_len, input first_payload_byte, input sequence_number,
    input applied_count, input duplicate_count, input bad_frame_count,
    input unknown_count, input bus_error_count, output ready
  );
endinterface

// File: rtl/cfvd_frame_asm.sv
module cfvd_frame_asm
  import cfvd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [1:0]        action,
  input  logic [7:0]        data_byte,
  output frame_info_t       info,
  output logic [CODE_W-1:0] lookup_code
);

  localparam logic [7:0] COUNT_LIMIT = 8'(FIXED_BYTES + MAX_PAYLOAD + 1);

  logic [7:0] cnt_r,   cnt_nxt;
  logic [7:0] xor_r,   xor_nxt;
  logic [7:0] first_r, first_nxt;
  logic [7:0] len_r,   len_nxt;
  logic [7:0] phead_r, phead_nxt;
  logic [7:0] prev_r,  prev_nxt;
  logic [7:0] last_r,  last_nxt;

  always_comb begin
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    first_nxt = first_r;
    len_nxt   = len_r;
    phead_nxt = phead_r;
    prev_nxt  = prev_r;
    last_nxt  = last_r;
    if (accept) begin
      case (action_t'(action))
        ACT_DATA: begin
          if (cnt_r == 8'd0) first_nxt = data_byte;
          else if (cnt_r == 8'd1) len_nxt = data_byte;
          else if (cnt_r == 8'd2) phead_nxt = data_byte;
          prev_nxt = last_r;
          last_nxt = data_byte;
          xor_nxt  = xor_r ^ data_byte;
          if (cnt_r < COUNT_LIMIT) cnt_nxt = cnt_r + 8'd1;
        end
        ACT_START, ACT_STOP, ACT_BUSERR: begin
          cnt_nxt   = '0;
          xor_nxt   = '0;
          first_nxt = '0;
          len_nxt   = '0;
          phead_nxt = '0;
          prev_nxt  = '0;
          last_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      xor_r   <= '0;
      first_r <= '0;
      len_r   <= '0;
      phead_r <= '0;
      prev_r  <= '0;
      last_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      first_r <= first_nxt;
      len_r   <= len_nxt;
      phead_r <= phead_nxt;
      prev_r  <= prev_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    info.nonempty = (cnt_r != 8'd0);
    info.ok       = (cnt_r >= 8'(FIXED_BYTES)) && (len_r <= 8'(MAX_PAYLOAD)) &&
                    ({1'b0, cnt_r} == (9'(FIXED_BYTES) + {1'b0, len_r})) &&
                    (xor_r == 8'd0);
    info.cmd      = first_r;
    info.len      = len_r;
    info.phead    = (len_r != 8'd0) ? phead_r : 8'd0;
    info.seq      = prev_r;
  end

  // table is read ahead, addressed by the code the next cycle will hold
  assign lookup_code = first_nxt[CODE_W-1:0];

endmodule

// File: rtl/cfvd_seq_table.sv
module cfvd_seq_table
  import cfvd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CODE_W-1:0] rd_addr,
  output logic              rd_valid,
  output logic [7:0]        rd_seq,
  input  logic              wr_en,
  input  logic [CODE_W-1:0] wr_addr,
  input  logic [7:0]        wr_seq
);

  logic [7:0]           mem [NUM_CODES];
  logic [NUM_CODES-1:0] valid_r;
  logic                 rd_valid_r;
  logic [7:0]           rd_seq_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_seq;
    rd_seq_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) valid_r[wr_addr] <= 1'b1;
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_seq   = rd_seq_r;

endmodule

// File: rtl/command_frame_validator_dedup_top.sv
// A stop that ends a nonempty frame shows its result in the cycle after acceptance.
// Throughput: one bus event per cycle while the input side is free; the output register frees
// the input side whenever it is empty or being read in the same cycle.
// Reset (rst_n low, synchronous): frame state, sequence table valid bits and
// statistics counters clear at once; no clearing pass.
module command_frame_validator_dedup_top
  import cfvd_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
  parameter int unsigned COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cfvd_in_if.sink     in_ch,
  cfvd_out_if.source  out_ch
);

  logic                    in_accept;
  logic                    is_stop;
  logic                    emit;
  logic                    is_dup;
  logic                    tbl_wr;
  frame_info_t             info;
  logic [CODE_W-1:0]       lookup_code;
  logic [CODE_W-1:0]       code;
  logic                    rd_valid;
  logic [7:0]              rd_seq;
  status_t                 status;
  logic [COUNTER_BITS-1:0] cnt_r   [NUM_CTRS];
  logic [COUNTER_BITS-1:0] cnt_nxt [NUM_CTRS];
  logic                    out_valid_r;
  result_t                 res_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign is_stop     = in_accept && (action_t'(in_ch.action) == ACT_STOP);
  assign emit        = is_stop && info.nonempty;

  cfvd_frame_asm #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .action      (in_ch.action),
    .data_byte   (in_ch.data_byte),
    .info        (info),
    .lookup_code (lookup_code)
  );

  assign code   = info.cmd[CODE_W-1:0];
  assign is_dup = rd_valid && (rd_seq == info.seq);
  assign tbl_wr = emit && info.ok && !is_dup;

  cfvd_seq_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (lookup_code),
    .rd_valid (rd_valid),
    .rd_seq   (rd_seq),
    .wr_en    (tbl_wr),
    .wr_addr  (code),
    .wr_seq   (info.seq)
  );

  always_comb begin
    if (!info.ok) status = ST_BAD;
    else if (is_dup) status = ST_DUP;
    else if (code_known(code)) status = ST_APPLIED;
    else status = ST_UNKNOWN;
  end

  always_comb begin
    for (int i = 0; i < NUM_CTRS; i++) cnt_nxt[i] = cnt_r[i];
    if (emit) begin
      case (status)
        ST_APPLIED: cnt_nxt[CT_APPLIED] = cnt_r[CT_APPLIED] + 1'b1;
        ST_DUP:     cnt_nxt[CT_DUP]     = cnt_r[CT_DUP] + 1'b1;
        ST_BAD:     cnt_nxt[CT_BAD]     = cnt_r[CT_BAD] + 1'b1;
        ST_UNKNOWN: cnt_nxt[CT_UNKNOWN] = cnt_r[CT_UNKNOWN] + 1'b1;
        default: begin
        end
      endcase
    end
    if (in_accept && (action_t'(in_ch.action) == ACT_BUSERR)) begin
      cnt_nxt[CT_BUSERR] = cnt_r[CT_BUSERR] + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CTRS; i++) cnt_r[i] <= '0;
      out_valid_r <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_CTRS; i++) cnt_r[i] <= cnt_nxt[i];
      if (emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r.status             <= status;
      res_r.command_code       <= info.ok ? code : '0;
      res_r.timing_quant       <= info.ok ? info.cmd[7:6] : 2'd0;
      res_r.body_len           <= info.ok ? info.len : 8'd0;
      res_r.first_payload_byte <= info.ok ? info.phead : 8'd0;
      res_r.sequence_number    <= info.ok ? info.seq : 8'd0;
      res_r.applied_count      <= 16'(cnt_nxt[CT_APPLIED]);
      res_r.duplicate_count    <= 16'(cnt_nxt[CT_DUP]);
      res_r.bad_frame_count    <= 16'(cnt_nxt[CT_BAD]);
      res_r.unknown_count      <= 16'(cnt_nxt[CT_UNKNOWN]);
      res_r.bus_error_count    <= 16'(cnt_nxt[CT_BUSERR]);
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = res_r.status;
  assign out_ch.command_code       = res_r.command_code;
  assign out_ch.timing_quant       = res_r.timing_quant;
  assign out_ch.body_len           = res_r.body_len;
  assign out_ch.first_payload_byte = res_r.first_payload_byte;
  assign out_ch.sequence_number    = res_r.sequence_number;
  assign out_ch.applied_count      = res_r.applied_count;
  assign out_ch.duplicate_count    = res_r.duplicate_count;
  assign out_ch.bad_frame_count    = res_r.bad_frame_count;
  assign out_ch.unknown_count      = res_r.unknown_count;
  assign out_ch.bus_error_count    = res_r.bus_error_count;

endmodule
